// ===== rtl/core/soa_pkg.sv =====
package soa_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan_run;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/soa_req_if.sv =====
interface soa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] thread_num;
  logic [7:0] slot_index;

  modport source (output valid, req_type, thread_num, slot_index, input ready);
  modport sink (input valid, req_type, thread_num, slot_index, output ready);
endinterface

// ===== rtl/core/soa_rsp_if.sv =====
interface soa_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot;
  logic [31:0] client_id;
  logic [1:0]  status;

  modport source (output valid, slot, client_id, status, input ready);
  modport sink (input valid, slot, client_id, status, output ready);
endinterface

// ===== rtl/core/slot_allocator_oldest_free_reuse.sv =====
// allocate: accept, then the scan, then the finish state; the scan reads one table
// entry per cycle through one memory port; finish waits for the output register
// tick and free skip the scan; one request in flight at a time
// reset clears counters, high-water mark and timeout at once; the table gets no
// clearing pass, as entries at or above the high-water mark are never read
module slot_allocator_oldest_free_reuse #(
  parameter int SLOTS     = 256,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  soa_req_if.sink     req,
  soa_rsp_if.source   rsp
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  soa_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== rtl/core/soa_ctrl.sv =====
module soa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  soa_pkg::sts_t sts_i,
  output soa_pkg::cmd_t cmd_o
);

  soa_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      soa_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_d = sts_i.in_alloc ? soa_pkg::S_SCAN : soa_pkg::S_FINISH;
        end
      end
      soa_pkg::S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = soa_pkg::S_FINISH;
        end
      end
      soa_pkg::S_FINISH: begin
        // wait until the output register can take the result beat
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = soa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = soa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/soa_dp.sv =====
module soa_dp #(
  parameter int SLOTS     = 256,
  parameter int TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  soa_req_if.sink       req,
  soa_rsp_if.source     rsp,
  input  soa_pkg::cmd_t cmd_i,
  output soa_pkg::sts_t sts_o
);

  localparam int AW    = $clog2(SLOTS);
  localparam int HW_W  = AW + 1;
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int IW    = (HW_W > 8) ? HW_W : 8;

  // slot table: used mark on top of the time of the last allocate or free
  logic [TIME_BITS:0] tmem [SLOTS];
  logic [7:0]         omem [SLOTS];

  soa_pkg::req_e        req_q;
  logic [7:0]           thr_q;
  logic [7:0]           idx_q;
  logic [HW_W-1:0]      hw_q;
  logic [31:0]          next_client_q;
  logic [TIME_BITS-1:0] now_q;
  logic [31:0]          timeout_q;

  logic [HW_W-1:0]      rd_addr_q;
  logic                 rd_vld_q;
  logic [AW-1:0]        rd_idx_q;
  logic [TIME_BITS:0]   rd_word_q;
  logic                 found_q;
  logic [AW-1:0]        best_idx_q;
  logic [TIME_BITS-1:0] best_age_q;

  logic                 out_valid_q;
  logic [7:0]           out_slot_q;
  logic [31:0]          out_cid_q;
  soa_pkg::status_e     out_sts_q;

  soa_pkg::req_e        in_req;
  logic                 accept;
  logic                 issue;
  logic [TIME_BITS-1:0] age;
  logic                 better;
  logic                 reuse;
  logic                 full;
  logic                 in_range;

  logic                 wr_en;
  logic                 own_en;
  logic                 wr_used;
  logic [AW-1:0]        wr_addr;
  logic                 hw_inc;
  logic                 ncl_inc;
  logic                 now_inc;
  logic [7:0]           res_slot;
  logic [31:0]          res_cid;
  soa_pkg::status_e     res_sts;

  assign in_req    = soa_pkg::req_e'(req.req_type);
  assign req.ready = cmd_i.in_ready;
  assign accept    = req.valid && cmd_i.in_ready;

  assign issue  = rd_addr_q < hw_q;
  assign age    = now_q - rd_word_q[TIME_BITS-1:0];
  assign better = rd_vld_q && !rd_word_q[TIME_BITS] && (!found_q || (age > best_age_q));

  assign sts_o.in_valid  = req.valid;
  assign sts_o.in_alloc  = (in_req == soa_pkg::REQ_ALLOC);
  assign sts_o.scan_done = !issue && !rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || rsp.ready;

  assign reuse    = found_q && (CMP_W'(best_age_q) >= CMP_W'(timeout_q));
  assign full     = hw_q >= HW_W'(SLOTS);
  assign in_range = IW'(idx_q) < IW'(hw_q);

  always_comb begin
    wr_en    = 1'b0;
    own_en   = 1'b0;
    wr_used  = 1'b0;
    wr_addr  = '0;
    hw_inc   = 1'b0;
    ncl_inc  = 1'b0;
    now_inc  = 1'b0;
    res_slot = '0;
    res_cid  = '0;
    res_sts  = soa_pkg::STS_OK;
    unique case (req_q)
      soa_pkg::REQ_TICK: begin
        now_inc = 1'b1;
      end
      soa_pkg::REQ_ALLOC: begin
        priority if (reuse) begin
          wr_addr = best_idx_q;
        end else if (full) begin
          res_sts = soa_pkg::STS_FULL;
        end else begin
          wr_addr = AW'(hw_q);
          hw_inc  = 1'b1;
        end
        if (reuse || !full) begin
          wr_en    = 1'b1;
          own_en   = 1'b1;
          wr_used  = 1'b1;
          ncl_inc  = 1'b1;
          res_slot = 8'(wr_addr);
          res_cid  = next_client_q;
        end
      end
      soa_pkg::REQ_FREE: begin
        res_slot = idx_q;
        if (in_range) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_q);
        end else begin
          res_sts = soa_pkg::STS_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      tmem[wr_addr] <= {wr_used, now_q};
    end
    if (cmd_i.commit && own_en) begin
      omem[wr_addr] <= thr_q;
    end
    rd_word_q <= tmem[rd_addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req;
      thr_q <= req.thread_num;
      idx_q <= req.slot_index;
    end
    if (cmd_i.scan_run && issue) begin
      rd_idx_q <= rd_addr_q[AW-1:0];
    end
    if (cmd_i.scan_run && better) begin
      best_idx_q <= rd_idx_q;
      best_age_q <= age;
    end
    if (cmd_i.commit) begin
      out_slot_q <= res_slot;
      out_cid_q  <= res_cid;
      out_sts_q  <= res_sts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q          <= '0;
      next_client_q <= '0;
      now_q         <= '0;
      timeout_q     <= '0;
      rd_addr_q     <= '0;
      rd_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      // slot 0 is reserved by the first allocate
      if (accept && (in_req == soa_pkg::REQ_ALLOC) && (hw_q == '0)) begin
        hw_q <= HW_W'(1);
      end else if (cmd_i.commit && hw_inc) begin
        hw_q <= hw_q + HW_W'(1);
      end
      if (cmd_i.commit && ncl_inc) begin
        next_client_q <= next_client_q + 32'd1;
      end
      if (cmd_i.commit && now_inc) begin
        now_q <= now_q + TIME_BITS'(1);
      end
      if (accept) begin
        rd_addr_q <= HW_W'(1);
        rd_vld_q  <= 1'b0;
        found_q   <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rd_vld_q <= issue;
        if (issue) begin
          rd_addr_q <= rd_addr_q + HW_W'(1);
        end
        if (better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.slot      = out_slot_q;
  assign rsp.client_id = out_cid_q;
  assign rsp.status    = out_sts_q;

endmodule
